### rtl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared constants and the cosine table for the RGB to HSI pixel unit
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int AngleTop = 180;
  localparam int Quarter = 90;
  localparam int SearchSteps = 8;   // hue search steps = saturation divide steps
  localparam logic [63:0] Cos1Q30 = 64'd1073578288;

  typedef logic [Quarter:0][16:0] cos_tab_t;
  typedef logic [Quarter:0][32:0] cos_sq_tab_t;

  // cos(k deg) in Q16 for k = 0..90, from the Q30 recurrence
  // c(k+1) = 2 cos(1 deg) c(k) - c(k-1), rounded half up, clamped at zero;
  // 60 and 90 degrees are pinned to 1/2 and 0
  function automatic cos_tab_t build_cos_q16();
    cos_tab_t    t;
    logic [63:0] q30 [0:Quarter];
    logic [63:0] prod;
    logic [63:0] nxt;
    q30[0] = 64'd1 << 30;
    q30[1] = Cos1Q30;
    for (int k = 1; k < Quarter; k++) begin
      prod = 64'd2 * Cos1Q30 * q30[k] + (64'd1 << 29);
      nxt  = prod >> 30;
      q30[k+1] = (nxt > q30[k-1]) ? nxt - q30[k-1] : 64'd0;
    end
    q30[60] = 64'd1 << 29;
    q30[Quarter] = 64'd0;
    for (int k = 0; k <= Quarter; k++) t[k] = 17'((q30[k] + 64'd8192) >> 14);
    return t;
  endfunction

  localparam cos_tab_t COS_Q16 = build_cos_q16();

  // squares of the table entries, Q32
  function automatic cos_sq_tab_t build_cos_sq();
    cos_sq_tab_t t;
    for (int k = 0; k <= Quarter; k++) t[k] = 33'(COS_Q16[k]) * 33'(COS_Q16[k]);
    return t;
  endfunction

  localparam cos_sq_tab_t COS_SQ = build_cos_sq();

  // squared magnitude of cos(k deg), k = 0..180; cos(180-k) = -cos(k)
  function automatic logic [32:0] cos_sq(input logic [7:0] k);
    logic [7:0] j;
    j = (k > 8'(Quarter)) ? 8'(AngleTop) - k : k;
    return COS_SQ[j[6:0]];
  endfunction

  function automatic logic cos_neg(input logic [7:0] k);
    return k > 8'(Quarter);
  endfunction

endpackage

### rtl/rgb_to_hsi_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel: RGB pixel to hue / saturation / intensity converter
// Pipelined; hue is found by an 8-step binary search over a cosine table.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | valid ready red green blue                | in to block
//  out     | valid ready hue_degrees saturation_percent| block to out
//          | intensity_level                           |
//
// One item per clock while out_ready keeps up; out_valid rises once the input
// has passed the registered stages in order (one front stage, eight hue
// search stages that also carry the saturation divide, one output stage).
// Every stage advances together when the output register is free or taken;
// a stall freezes the whole pipe, nothing is lost or repeated.
// rst clears the valid bits only.
module rgb_to_hsi_pixel (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] hue_degrees,
  output logic [6:0] saturation_percent,
  output logic [7:0] intensity_level
);

  typedef struct packed {
    logic        gray;
    logic        bgt;       // blue > green
    logic        mneg;
    logic [17:0] am2;       // (2r-g-b)^2
    logic [16:0] dd;        // D, 0..65025
    logic [7:0]  lo;        // search window low
    logic [7:0]  hi;        // search window high
    logic [15:0] srem;      // saturation division remainder
    logic [15:0] snum;      // numerator bits left
    logic [9:0]  sden;      // sum
    logic [6:0]  squo;
    logic [7:0]  inten;
  } stage_t;

  logic         adv;
  logic         vld [0:rth_pkg::SearchSteps];
  stage_t       st  [0:rth_pkg::SearchSteps];
  stage_t       s0_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ------------------------------------------------------------------ front
  always_comb begin
    logic signed [9:0]  rg, rb, gb, m;
    logic [9:0]  sum, mn, am;
    logic signed [18:0] d;
    logic [19:0] iq;
    rg  = 10'(red) - 10'(green);
    rb  = 10'(red) - 10'(blue);
    gb  = 10'(green) - 10'(blue);
    m   = rg + rb;
    d   = 19'(rg) * 19'(rg) + 19'(rb) * 19'(gb);
    sum = 10'(red) + 10'(green) + 10'(blue);
    mn  = 10'(red);
    if (10'(green) < mn) mn = 10'(green);
    if (10'(blue) < mn) mn = 10'(blue);
    am  = m[9] ? 10'(-m) : 10'(m);
    // sum/3 as sum*683 >> 11, exact for sums up to 765
    iq  = 20'(sum) * 20'd683;
    s0_next.gray  = (red == green) && (green == blue);
    s0_next.bgt   = blue > green;
    s0_next.mneg  = m[9];
    s0_next.am2   = 18'(am) * 18'(am);
    s0_next.dd    = d[16:0];
    s0_next.lo    = 8'd0;
    s0_next.hi    = 8'(rth_pkg::AngleTop);
    s0_next.srem  = '0;
    s0_next.snum  = 16'(7'd100 * (sum - 10'd3 * mn));
    s0_next.sden  = sum;
    s0_next.squo  = '0;
    s0_next.inten = iq[18:11];
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= in_valid;
    if (adv) st[0] <= s0_next;
  end

  // ------------------------------------------------------ search/divide
  // Each stage halves the hue window and produces two quotient bits.
  // Floor case: largest k with x <= cos(k); ceil case: smallest k, x >= cos(k).
  for (genvar i = 0; i < rth_pkg::SearchSteps; i++) begin : g_stage
    stage_t sn;
    always_comb begin
      stage_t s;
      logic [7:0]  mid;
      logic [32:0] csq;
      logic        cneg, gt, lt;
      logic [49:0] lhs;
      logic [49:0] rhs;
      logic [16:0] tr;
      s   = st[i];
      sn  = s;
      // floor: probe upper mid; ceil: probe lower mid
      mid = s.bgt ? 8'((9'(s.lo) + 9'(s.hi)) >> 1)
                  : 8'((9'(s.lo) + 9'(s.hi) + 9'd1) >> 1);
      csq  = rth_pkg::cos_sq(mid);
      cneg = rth_pkg::cos_neg(mid) && (csq != 0);
      // |x| vs |cos|: am^2 * 2^30 against cos^2 (Q32) * dd
      lhs  = {2'b00, s.am2, 30'd0};
      rhs  = 50'(csq) * 50'(s.dd);
      if (s.am2 == 0 && csq == 0) begin
        gt = 1'b0; lt = 1'b0;
      end else if (s.am2 == 0) begin
        gt = cneg; lt = !cneg;
      end else if (csq == 0) begin
        gt = !s.mneg; lt = s.mneg;
      end else if (s.mneg != cneg) begin
        gt = !s.mneg; lt = s.mneg;
      end else begin
        gt = s.mneg ? (lhs < rhs) : (lhs > rhs);
        lt = s.mneg ? (lhs > rhs) : (lhs < rhs);
      end
      if (s.lo != s.hi) begin
        if (!s.bgt) begin
          if (gt) sn.hi = mid - 8'd1; else sn.lo = mid;
        end else begin
          if (lt) sn.lo = mid + 8'd1; else sn.hi = mid;
        end
      end
      // restoring divide step, 2 numerator bits per stage (16 bits / 8)
      tr = {s.srem[14:0], s.snum[15]} ;
      if (tr >= 17'(s.sden)) tr = tr - 17'(s.sden);
      sn.srem = {tr[14:0], s.snum[14]};
      sn.squo = s.squo;
      if (17'(sn.srem) >= 17'(s.sden)) begin
        sn.srem = 16'(17'(sn.srem) - 17'(s.sden));
      end
      sn.squo = 7'({s.squo, ({s.srem[14:0], s.snum[15]} >= 16'(s.sden)),
                  (17'({tr[14:0], s.snum[14]}) >= 17'(s.sden))});
      sn.snum = {s.snum[13:0], 2'b00};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (adv) vld[i+1] <= vld[i];
      if (adv) st[i+1] <= sn;
    end
  end

  // ----------------------------------------------------------------- output
  logic [8:0] hue_next;
  always_comb begin
    stage_t f;
    f = st[rth_pkg::SearchSteps];
    if (f.gray) hue_next = '0;
    else if (!f.bgt) hue_next = 9'(f.lo);
    else if (f.lo == 8'd0) hue_next = '0;
    else hue_next = 9'd360 - 9'(f.lo);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vld[rth_pkg::SearchSteps];
    if (adv) begin
      hue_degrees        <= hue_next;
      saturation_percent <= st[rth_pkg::SearchSteps].gray ? 7'd0
                                                          : st[rth_pkg::SearchSteps].squo;
      intensity_level    <= st[rth_pkg::SearchSteps].inten;
    end
  end

  // ------------------------------------------------------------- assertions
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> saturation_percent <= 7'd100) else $error("saturation out of range");
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue_degrees < 9'd360) else $error("hue out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue_degrees))
    else $error("stalled result changed");

endmodule
